// File: rtl/core/paxos_acceptor_assert.svh
// Assertion macros, clocked on clk, off while rst_n is low.
`ifndef PAXOS_ACCEPTOR_ASSERT_SVH
`define PAXOS_ACCEPTOR_ASSERT_SVH

// same-cycle implication
`define PXA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("paxos_acceptor: same-cycle check failed");

// next-cycle implication
`define PXA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("paxos_acceptor: next-cycle check failed");

`endif

// File: rtl/core/pxa_pkg.sv
`default_nettype none
package pxa_pkg;

  localparam int INSTANCES   = 65536;
  localparam int VALUE_WORDS = 8;
  localparam int PAIRS       = 4;
  localparam int IDX_W       = (INSTANCES > 1) ? $clog2(INSTANCES) : 1;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  localparam logic [5:0] TYPE_1A = 6'd1;
  localparam logic [5:0] TYPE_1B = 6'd2;
  localparam logic [5:0] TYPE_2A = 6'd4;
  localparam logic [5:0] TYPE_2B = 6'd8;

  localparam logic [3:0] DEV_ID_MIN   = 4'd1;
  localparam logic [3:0] DEV_ID_MAX   = 4'd8;
  localparam logic [3:0] DEV_ID_RESET = 4'd1;

  typedef logic [PAIRS-1:0][63:0] value_t;

  typedef enum logic [1:0] {
    ACT_DROP     = 2'd0,
    ACT_LEADER   = 2'd1,
    ACT_LEARNERS = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    CMD_DROP    = 2'd0,
    CMD_PREPARE = 2'd1,
    CMD_ACCEPT  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [5:0]  type_bits;
    logic [15:0] instance_req;
    logic [15:0] round;
    logic [63:0] value_01;
    logic [63:0] value_23;
    logic [63:0] value_45;
    logic [63:0] value_67;
  } in_req_t;

  typedef struct packed {
    action_t     action;
    logic [5:0]  reply_type;
    logic [15:0] reply_instance;
    logic [15:0] reply_round;
    logic [15:0] voted_round;
    logic [7:0]  vote_mask;
    logic [63:0] out_value_01;
    logic [63:0] out_value_23;
    logic [63:0] out_value_45;
    logic [63:0] out_value_67;
  } out_rsp_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] instance_req;
    logic [15:0] round;
    logic [7:0]  vote_mask;
    value_t      value;
  } cmd_t;

  // words at VALUE_WORDS and above are stored as zero
  function automatic value_t store_mask();
    value_t m;
    m = '0;
    for (int p = 0; p < PAIRS; p++) begin
      if (2 * p < VALUE_WORDS) m[p][31:0] = '1;
      if (2 * p + 1 < VALUE_WORDS) m[p][63:32] = '1;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/pxa_front.sv
`default_nettype none
module pxa_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_push,
  output logic                in_full,
  input  wire pxa_pkg::in_req_t in_data,
  input  wire logic           cfg_we,
  input  wire logic [3:0]     cfg_wdata,
  input  wire logic           clr_busy,
  output logic                q_push,
  input  wire logic           q_full,
  output pxa_pkg::cmd_t       q_wdata
);

  logic [3:0]  device_id_r;
  logic [3:0]  device_id_nxt;
  logic [16:0] inst_limit;
  logic        type_pass;
  logic        in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_id_r <= pxa_pkg::DEV_ID_RESET;
    end else begin
      device_id_r <= device_id_nxt;
    end
  end

  always_comb begin
    device_id_nxt = device_id_r;
    if (cfg_we) begin
      device_id_nxt = cfg_wdata;
    end
  end

  assign inst_limit = 17'(pxa_pkg::INSTANCES);
  assign type_pass  = (in_data.type_bits & (pxa_pkg::TYPE_1A | pxa_pkg::TYPE_2A)) != 6'd0;
  assign in_range   = {1'b0, in_data.instance_req} < inst_limit;

  assign in_full = q_full || clr_busy;
  assign q_push  = in_push && !in_full;

  always_comb begin
    q_wdata              = '0;
    q_wdata.instance_req = in_data.instance_req;
    q_wdata.round        = in_data.round;
    q_wdata.value        = {in_data.value_67, in_data.value_45,
                            in_data.value_23, in_data.value_01};
    if (device_id_r >= pxa_pkg::DEV_ID_MIN && device_id_r <= pxa_pkg::DEV_ID_MAX) begin
      q_wdata.vote_mask = 8'd1 << (device_id_r - pxa_pkg::DEV_ID_MIN);
    end
    if (!type_pass || !in_range) begin
      q_wdata.kind = pxa_pkg::CMD_DROP;
    end else if (in_data.type_bits == pxa_pkg::TYPE_1A) begin
      q_wdata.kind = pxa_pkg::CMD_PREPARE;
    end else begin
      q_wdata.kind = pxa_pkg::CMD_ACCEPT;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/pxa_cmd_fifo.sv
`default_nettype none
module pxa_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  output logic               full,
  input  wire pxa_pkg::cmd_t wdata,
  input  wire logic          pop,
  output logic               empty,
  output pxa_pkg::cmd_t      rdata
);

  pxa_pkg::cmd_t                   buf_r [pxa_pkg::CMDQ_DEPTH];
  logic [pxa_pkg::CMDQ_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [pxa_pkg::CMDQ_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [pxa_pkg::CMDQ_CNT_W-1:0]  cnt_r, cnt_nxt;

  localparam logic [pxa_pkg::CMDQ_PTR_W-1:0] PTR_LAST =
    pxa_pkg::CMDQ_PTR_W'(pxa_pkg::CMDQ_DEPTH - 1);
  localparam logic [pxa_pkg::CMDQ_CNT_W-1:0] CNT_FULL =
    pxa_pkg::CMDQ_CNT_W'(pxa_pkg::CMDQ_DEPTH);

  assign full  = cnt_r == CNT_FULL;
  assign empty = cnt_r == '0;
  assign rdata = buf_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/pxa_back.sv
`default_nettype none
`include "paxos_acceptor_assert.svh"
module pxa_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  wire pxa_pkg::cmd_t q_rdata,
  output logic               q_pop,
  output logic               clr_busy,
  output logic               out_empty,
  input  wire logic          out_pop,
  output pxa_pkg::out_rsp_t  out_data
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  localparam logic [pxa_pkg::IDX_W-1:0] IDX_LAST = pxa_pkg::IDX_W'(pxa_pkg::INSTANCES - 1);

  state_t                     state_r, state_nxt;
  logic [pxa_pkg::IDX_W-1:0]  clr_idx_r, clr_idx_nxt;
  pxa_pkg::cmd_t              cur_r;
  pxa_pkg::out_rsp_t          res_r, res_nxt;
  logic                       res_valid_r, res_valid_nxt;

  logic [15:0]                prom_mem  [pxa_pkg::INSTANCES];
  logic [15:0]                voted_mem [pxa_pkg::INSTANCES];
  pxa_pkg::value_t            value_mem [pxa_pkg::INSTANCES];
  logic [15:0]                prom_rd_r;
  logic [15:0]                voted_rd_r;
  pxa_pkg::value_t            value_rd_r;

  logic                       start;
  logic                       exec;
  logic                       passed;
  logic [pxa_pkg::IDX_W-1:0]  rd_addr;
  logic [pxa_pkg::IDX_W-1:0]  wr_addr;
  logic                       prom_we, voted_we, value_we;
  logic [15:0]                prom_wdata, voted_wdata;
  pxa_pkg::value_t            value_wdata;

  assign clr_busy  = state_r == ST_CLEAR;
  assign exec      = state_r == ST_EXEC;
  assign start     = (state_r == ST_IDLE) && !q_empty && (!res_valid_r || out_pop);
  assign q_pop     = start;
  assign rd_addr   = q_rdata.instance_req[pxa_pkg::IDX_W-1:0];
  assign passed    = (cur_r.kind != pxa_pkg::CMD_DROP) && !(prom_rd_r > cur_r.round);
  assign out_empty = !res_valid_r;
  assign out_data  = res_r;

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == IDX_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // store writes: zero sweep after reset, else compare-and-write of one request
  always_comb begin
    wr_addr     = cur_r.instance_req[pxa_pkg::IDX_W-1:0];
    prom_we     = 1'b0;
    voted_we    = 1'b0;
    value_we    = 1'b0;
    prom_wdata  = cur_r.round;
    voted_wdata = cur_r.round;
    value_wdata = cur_r.value & pxa_pkg::store_mask();
    if (clr_busy) begin
      wr_addr     = clr_idx_r;
      prom_we     = 1'b1;
      voted_we    = 1'b1;
      value_we    = 1'b1;
      prom_wdata  = '0;
      voted_wdata = '0;
      value_wdata = '0;
    end else if (exec && passed) begin
      prom_we  = 1'b1;
      voted_we = cur_r.kind == pxa_pkg::CMD_ACCEPT;
      value_we = cur_r.kind == pxa_pkg::CMD_ACCEPT;
    end
  end

  always_comb begin
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r;
    if (out_pop && res_valid_r) begin
      res_valid_nxt = 1'b0;
    end
    if (exec) begin
      res_valid_nxt = 1'b1;
      res_nxt       = '0;
      if (passed) begin
        res_nxt.reply_instance = cur_r.instance_req;
        res_nxt.reply_round    = cur_r.round;
        res_nxt.vote_mask      = cur_r.vote_mask;
        if (cur_r.kind == pxa_pkg::CMD_PREPARE) begin
          res_nxt.action       = pxa_pkg::ACT_LEADER;
          res_nxt.reply_type   = pxa_pkg::TYPE_1B;
          res_nxt.voted_round  = voted_rd_r;
          res_nxt.out_value_01 = value_rd_r[0];
          res_nxt.out_value_23 = value_rd_r[1];
          res_nxt.out_value_45 = value_rd_r[2];
          res_nxt.out_value_67 = value_rd_r[3];
        end else begin
          res_nxt.action       = pxa_pkg::ACT_LEARNERS;
          res_nxt.reply_type   = pxa_pkg::TYPE_2B;
          res_nxt.out_value_01 = cur_r.value[0];
          res_nxt.out_value_23 = cur_r.value[1];
          res_nxt.out_value_45 = cur_r.value[2];
          res_nxt.out_value_67 = cur_r.value[3];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (start) begin
      cur_r <= q_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (prom_we) begin
      prom_mem[wr_addr] <= prom_wdata;
    end
    if (start) begin
      prom_rd_r <= prom_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (voted_we) begin
      voted_mem[wr_addr] <= voted_wdata;
    end
    if (start) begin
      voted_rd_r <= voted_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (value_we) begin
      value_mem[wr_addr] <= value_wdata;
    end
    if (start) begin
      value_rd_r <= value_mem[rd_addr];
    end
  end

  `PXA_ASSERT_IMP(a_exec_slot_free, exec, !res_valid_r)
  `PXA_ASSERT_NXT(a_start_to_exec, start, state_r == ST_EXEC)
  `PXA_ASSERT_NXT(a_exec_gives_rsp, exec, res_valid_r)
  `PXA_ASSERT_IMP(a_no_pop_clear, clr_busy, !q_pop && !res_valid_r)

endmodule
`default_nettype wire

// File: rtl/core/paxos_acceptor.sv
// channel   ports                          moves
// in        in_push, in_full, in_data      one message request
// out       out_pop, out_empty, out_data   one reply request, oldest first
// cfg       cfg_we, cfg_wdata              device id, no read-back
//
// Back end takes one request at a time: registered store read, then compare-and-write.
// A 2-deep command queue lets input be taken while a reply waits on out.
// After reset the stores are zeroed, one instance per cycle over all 65536 instances, in_full high.
// cfg writes are taken at any time, including the zeroing pass.
`default_nettype none
module paxos_acceptor (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire pxa_pkg::in_req_t  in_data,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output pxa_pkg::out_rsp_t      out_data,
  input  wire logic              cfg_we,
  input  wire logic [3:0]        cfg_wdata
);

  logic          clr_busy;
  logic          q_push, q_full, q_pop, q_empty;
  pxa_pkg::cmd_t q_wdata, q_rdata;

  pxa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .clr_busy  (clr_busy),
    .q_push    (q_push),
    .q_full    (q_full),
    .q_wdata   (q_wdata)
  );

  pxa_cmd_fifo u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .full  (q_full),
    .wdata (q_wdata),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  pxa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .clr_busy  (clr_busy),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT = 3 * pxa_pkg::INSTANCES;
  localparam int DRAIN_CYCLES   = 8;
  localparam int LONG_HOLD      = 64;
  localparam int PHASE_ITEMS    = 205;

  localparam logic [5:0] NO_TYPE_BITS  = 6'd0;
  localparam logic [5:0] ALL_TYPE_BITS = 6'h3F;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_push = 1'b0;
  logic     in_full;
  pxa_pkg::in_req_t  in_data = '0;
  logic     out_empty;
  logic     out_pop = 1'b0;
  pxa_pkg::out_rsp_t out_data;
  logic     cfg_we = 1'b0;
  logic [3:0] cfg_wdata = 4'd0;

  paxos_acceptor dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // acceptor state as the block should hold it
  logic [3:0]  acceptor_id = pxa_pkg::DEV_ID_RESET;
  logic [15:0] promised_tbl [int unsigned];
  logic [15:0] voted_tbl [int unsigned];
  pxa_pkg::value_t value_tbl [int unsigned];
  logic [15:0] ballot_hint [int unsigned];

  pxa_pkg::in_req_t  msgs_to_send [$];
  pxa_pkg::out_rsp_t replies_due [$];

  int  mismatches = 0;
  int  n_prepares = 0;
  int  n_accepts = 0;
  int  n_drops = 0;
  int  id_writes = 0;
  int  quiet_cycles = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  bit  calm = 1'b0;
  bit  hold_off_pending = 1'b0;

  function automatic pxa_pkg::in_req_t mk_msg(logic [5:0] t, logic [15:0] inst,
                                              logic [15:0] rnd);
    pxa_pkg::in_req_t m;
    m.type_bits    = t;
    m.instance_req = inst;
    m.round        = rnd;
    m.value_01     = {$urandom, $urandom};
    m.value_23     = {$urandom, $urandom};
    m.value_45     = {$urandom, $urandom};
    m.value_67     = {$urandom, $urandom};
    return m;
  endfunction

  task automatic compute_reply(input pxa_pkg::in_req_t m);
    pxa_pkg::out_rsp_t r;
    int unsigned       inst;
    logic [15:0]       prom;
    pxa_pkg::value_t   v;
    pxa_pkg::value_t   keep;
    inst = 32'(m.instance_req);
    r = '0;
    if ((m.type_bits & (pxa_pkg::TYPE_1A | pxa_pkg::TYPE_2A)) != 6'd0 &&
        inst < pxa_pkg::INSTANCES) begin
      prom = promised_tbl.exists(inst) ? promised_tbl[inst] : 16'd0;
      if (prom <= m.round) begin
        promised_tbl[inst] = m.round;
        r.reply_instance = m.instance_req;
        r.reply_round = m.round;
        if (acceptor_id >= pxa_pkg::DEV_ID_MIN && acceptor_id <= pxa_pkg::DEV_ID_MAX)
          r.vote_mask = 8'd1 << (acceptor_id - 4'd1);
        if (m.type_bits == pxa_pkg::TYPE_1A) begin
          v = value_tbl.exists(inst) ? value_tbl[inst] : '0;
          r.action = pxa_pkg::ACT_LEADER;
          r.reply_type = pxa_pkg::TYPE_1B;
          r.voted_round = voted_tbl.exists(inst) ? voted_tbl[inst] : 16'd0;
          n_prepares++;
        end else begin
          v = {m.value_67, m.value_45, m.value_23, m.value_01};
          keep = '0;
          for (int p = 0; p < pxa_pkg::PAIRS; p++) begin
            if (2 * p < pxa_pkg::VALUE_WORDS) keep[p][31:0] = '1;
            if (2 * p + 1 < pxa_pkg::VALUE_WORDS) keep[p][63:32] = '1;
          end
          r.action = pxa_pkg::ACT_LEARNERS;
          r.reply_type = pxa_pkg::TYPE_2B;
          voted_tbl[inst] = m.round;
          value_tbl[inst] = v & keep;
          n_accepts++;
        end
        r.out_value_01 = v[0];
        r.out_value_23 = v[1];
        r.out_value_45 = v[2];
        r.out_value_67 = v[3];
      end
    end
    if (r.action == pxa_pkg::ACT_DROP) n_drops++;
    replies_due.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      mismatches++;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) compute_reply(msgs_to_send.pop_front());
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (send_gap > 0) begin
      send_gap--;
      in_push <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      send_gap = $urandom_range(0, 17);
      in_push <= 1'b0;
    end else if (msgs_to_send.size() > 0) begin
      in_push <= 1'b1;
      in_data <= msgs_to_send[0];
    end else begin
      in_push <= 1'b0;
    end
  end

  // reply monitor
  always @(posedge clk) begin
    pxa_pkg::out_rsp_t e;
    if (rst_n && out_pop && !out_empty) begin
      if (replies_due.size() == 0) begin
        $error("reply request with no message outstanding");
        mismatches++;
      end else begin
        e = replies_due.pop_front();
        check_field("action", 64'(e.action), 64'(out_data.action));
        check_field("reply_type", 64'(e.reply_type), 64'(out_data.reply_type));
        check_field("reply_instance", 64'(e.reply_instance),
                    64'(out_data.reply_instance));
        check_field("reply_round", 64'(e.reply_round), 64'(out_data.reply_round));
        check_field("voted_round", 64'(e.voted_round), 64'(out_data.voted_round));
        check_field("vote_mask", 64'(e.vote_mask), 64'(out_data.vote_mask));
        check_field("out_value_01", e.out_value_01, out_data.out_value_01);
        check_field("out_value_23", e.out_value_23, out_data.out_value_23);
        check_field("out_value_45", e.out_value_45, out_data.out_value_45);
        check_field("out_value_67", e.out_value_67, out_data.out_value_67);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_pop <= 1'b0;
    end else if (hold_off_pending) begin
      hold_off_pending = 1'b0;
      stall_left = LONG_HOLD - 1;
      out_pop <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 17);
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  // watchdog; the zeroing pass after reset is the longest quiet stretch
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic wait_idle();
    while (msgs_to_send.size() != 0 || replies_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_device(input logic [3:0] id);
    wait_idle();
    cfg_wdata <= id;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    acceptor_id = id;
    id_writes++;
  endtask

  task automatic push_msg(input pxa_pkg::in_req_t m);
    msgs_to_send.push_back(m);
  endtask

  task automatic load_directed();
    pxa_pkg::in_req_t m;
    push_msg(mk_msg(pxa_pkg::TYPE_1A, 16'd0, 16'd0));
    m = mk_msg(pxa_pkg::TYPE_2A, 16'd0, 16'd0);
    m.value_01 = '1; m.value_23 = '1; m.value_45 = '1; m.value_67 = '1;
    push_msg(m);
    push_msg(mk_msg(pxa_pkg::TYPE_1A, 16'd0, 16'd0));
    push_msg(mk_msg(NO_TYPE_BITS, 16'd0, 16'hFFFF));
    push_msg(mk_msg(pxa_pkg::TYPE_1B, 16'd0, 16'd5));
    push_msg(mk_msg(pxa_pkg::TYPE_2B, 16'd0, 16'd5));
    push_msg(mk_msg(ALL_TYPE_BITS, 16'd0, 16'd3));
    push_msg(mk_msg(pxa_pkg::TYPE_1A | pxa_pkg::TYPE_2A, 16'd0, 16'd3));
    push_msg(mk_msg(pxa_pkg::TYPE_1A | pxa_pkg::TYPE_1B, 16'd0, 16'd4));
    // stale rounds
    push_msg(mk_msg(pxa_pkg::TYPE_1A, 16'd0, 16'd2));
    push_msg(mk_msg(pxa_pkg::TYPE_2A, 16'd0, 16'd2));
    push_msg(mk_msg(pxa_pkg::TYPE_1A, 16'd0, 16'd4));
    m = mk_msg(pxa_pkg::TYPE_2A, 16'hFFFF, 16'hFFFF);
    m.value_01 = {32{2'b10}}; m.value_23 = {32{2'b01}};
    m.value_45 = {32{2'b10}}; m.value_67 = {32{2'b01}};
    push_msg(m);
    push_msg(mk_msg(pxa_pkg::TYPE_1A, 16'hFFFF, 16'hFFFF));
    push_msg(mk_msg(pxa_pkg::TYPE_1A, 16'hFFFF, 16'hFFFE));
    push_msg(mk_msg(ALL_TYPE_BITS & ~pxa_pkg::TYPE_1A, 16'h5555, 16'hAAAA));
    push_msg(mk_msg(pxa_pkg::TYPE_1A, 16'hAAAA, 16'h5555));
    m = mk_msg(pxa_pkg::TYPE_2A, 16'hAAAA, 16'h5555);
    m.value_01 = '0; m.value_23 = '0; m.value_45 = '0; m.value_67 = '0;
    push_msg(m);
    push_msg(mk_msg(pxa_pkg::TYPE_1A, 16'hAAAA, 16'h5556));
    push_msg(mk_msg(ALL_TYPE_BITS & ~(pxa_pkg::TYPE_1A | pxa_pkg::TYPE_2A),
                    16'hAAAA, 16'hFFFF));
  endtask

  // mostly prepare/accept rounds on a few hot instances, plus noise
  task automatic load_random(input int n);
    int               made;
    int               kind;
    int unsigned      inst;
    logic [15:0]      rnd;
    pxa_pkg::in_req_t m;
    int unsigned      pool [6];
    made = 0;
    foreach (pool[i]) pool[i] = $urandom_range(0, 65535);
    while (made < n) begin
      kind = $urandom_range(0, 9);
      inst = pool[$urandom_range(0, 5)];
      rnd = ballot_hint.exists(inst) ? ballot_hint[inst] : 16'd0;
      if (kind < 7) begin
        if (rnd < 16'hFFFD) rnd += 16'($urandom_range(0, 2));
        ballot_hint[inst] = rnd;
        push_msg(mk_msg(pxa_pkg::TYPE_1A, 16'(inst), rnd));
        m = mk_msg(pxa_pkg::TYPE_2A, 16'(inst), rnd);
        if ($urandom_range(0, 5) == 0) m.type_bits = pxa_pkg::TYPE_1A | pxa_pkg::TYPE_2A;
        push_msg(m);
        made += 2;
        case ($urandom_range(0, 3))
          0: begin
            push_msg(mk_msg(pxa_pkg::TYPE_1A, 16'(inst), rnd));
            made++;
          end
          1: begin
            if (rnd > 16'd0) begin
              push_msg(mk_msg(pxa_pkg::TYPE_2A, 16'(inst), rnd - 16'd1));
              made++;
            end
          end
          default: ;
        endcase
      end else if (kind < 9) begin
        push_msg(mk_msg(6'($urandom_range(0, 63)), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535))));
        made++;
      end else begin
        // accept without a prepare, near the current ballot
        if (rnd > 16'd0) rnd -= 16'd1;
        push_msg(mk_msg(pxa_pkg::TYPE_2A, 16'(inst), rnd + 16'($urandom_range(0, 2))));
        made++;
      end
    end
  endtask

  logic [3:0] phase_ids [8] = '{4'd8, 4'd0, 4'd15, 4'd9, 4'd3, 4'd6, 4'd2, 4'd5};

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    set_device(pxa_pkg::DEV_ID_MIN);
    load_directed();
    foreach (phase_ids[i]) begin
      set_device(phase_ids[i]);
      if (i == 1) hold_off_pending = 1'b1;
      if (i == $size(phase_ids) - 1) calm = 1'b1;
      load_random(PHASE_ITEMS);
    end
    wait_idle();
    $display("Covered %0d messages: %0d prepares answered, %0d accepts, %0d dropped,",
             n_prepares + n_accepts + n_drops, n_prepares, n_accepts, n_drops);
    $display("over %0d device id settings with input back-pressure and reply stalls.",
             id_writes);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: paxos_acceptor.f
+incdir+rtl/core
rtl/core/pxa_pkg.sv
rtl/core/pxa_front.sv
rtl/core/pxa_cmd_fifo.sv
rtl/core/pxa_back.sv
rtl/core/paxos_acceptor.sv
tb/testbench.sv
